@@ hdl/urc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner package
// Word types, register map, arithmetic constants and window sizing shared by
// the front end, the queue, the back end and the checker.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int DUR_W      = 16;
  localparam int DIST_W     = 13;
  localparam int CNT_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Speed of sound in mm/s per 1000: SOS_BASE + SOS_SLOPE * temperature.
  localparam int SOS_W  = 19;
  localparam int SOSX_W = 20;
  localparam logic [SOSX_W-1:0] SOS_BASE  = 20'd331300;
  localparam logic [SOSX_W-1:0] SOS_SLOPE = 20'd606;

  // Product of duration and speed, and the range limits on it.
  localparam int P_W = 35;
  localparam logic [P_W-1:0] RANGE_LO   = 35'd40000000;
  localparam logic [P_W-1:0] RANGE_HI   = 35'd8000000000;
  localparam logic [P_W-1:0] ROUND_HALF = 35'd625000;

  // Division by 1250000 = 16 * 78125, the second factor by reciprocal.
  localparam int X_W      = 29;
  localparam int RECIP_W  = 24;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam int RECIP_SH = 40;
  localparam int QM_W     = 30;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd14073748;
  localparam logic [16:0]        DIV_RES = 17'd78125;

  localparam logic [DIST_W-1:0] CONFIRM_Q4  = 13'd240;
  localparam logic [CNT_W-1:0]  DEGRADE_RUN = 8'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 8'hFF;
  localparam logic [DIST_W-1:0] LAST_RESET  = 13'd480;

  localparam int WINDOW    = 5;
  localparam int WIN_IDX_W = $clog2(WINDOW);
  localparam int WIN_CNT_W = $clog2(WINDOW + 1);
  localparam int MED_RANK  = WINDOW / 2;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int PING_W = 2;
  localparam int PINGS  = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AMBIENT_TEMP       = 3'd0,
    CFG_ECHO_TIMEOUT       = 3'd1,
    CFG_JUMP_LIMIT         = 3'd2,
    CFG_STILL_BAND         = 3'd3,
    CFG_STUCK_LIMIT        = 3'd4,
    CFG_FAIL_LIMIT         = 3'd5,
    CFG_OBSTACLE_THRESHOLD = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HEALTH_OK       = 2'd0,
    HEALTH_DEGRADED = 2'd1,
    HEALTH_FAILED   = 2'd2
  } health_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ISSUE,
    F_WAIT,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_SCAN
  } back_state_e;

  typedef struct packed {
    logic signed [7:0]  ambient_temp;
    logic [DUR_W-1:0]   echo_timeout;
    logic [DIST_W-1:0]  jump_limit;
    logic [DIST_W-1:0]  still_band;
    logic [CNT_W-1:0]   stuck_limit;
    logic [CNT_W-1:0]   fail_limit;
    logic [DIST_W-1:0]  obstacle_threshold;
  } cfg_t;

  typedef struct packed {
    logic [DUR_W-1:0] echo_time_a;
    logic [DUR_W-1:0] echo_time_b;
    logic [DUR_W-1:0] echo_time_c;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q4;
    logic              distance_valid;
    logic              held_value;
    logic [1:0]        sensor_health;
    logic              obstacle_near;
  } out_word_t;

  typedef struct packed {
    logic              fail;
    logic [DIST_W-1:0] raw;
  } qword_t;

endpackage
`default_nettype wire

@@ hdl/urc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner front end
// Converts the three echo durations of a word through one shared pipelined
// converter and merges the valid pings into one raw distance or a failure.
// ----------------------------------------------------------------------------
module urc_front import urc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  output logic     full_o,
  input  in_word_t in_word_i,
  output logic     q_push_o,
  input  logic     q_full_i,
  output qword_t   q_word_o
);

  front_state_e state_q, state_d;
  in_word_t     in_q;
  logic         in_we;
  logic [PING_W-1:0] iss_q, iss_d;
  logic         issue;

  logic [SOSX_W-1:0] sos_w;
  logic [SOS_W-1:0]  sos;
  logic [DUR_W-1:0]  dur;
  logic              dur_ok;

  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic              s1_ok_q, s2_ok_q, s3_ok_q, s4_ok_q;
  logic [PING_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [P_W-1:0]    s1_p_q;
  logic [P_W-1:0]    p_round;
  logic [X_W-1:0]    s2_x_q, s3_x_q, s4_x_q;
  logic [PROD_W-1:0] recip_prod;
  logic [DIST_W-1:0] s3_qe_q, s4_qe_q;
  logic [X_W-1:0]    s4_qm_q;
  logic [X_W-1:0]    rem;
  logic [DIST_W-1:0] q_fix;

  logic [DIST_W-1:0] res_q [PINGS];
  logic [PINGS-1:0]  rok_q;

  function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [DIST_W-1:0] med3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      iss_q   <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    iss_d    = iss_q;
    in_we    = 1'b0;
    issue    = 1'b0;
    q_push_o = 1'b0;
    full_o   = 1'b1;
    unique case (state_q)
      F_IDLE: begin
        full_o = 1'b0;
        if (push_i) begin
          in_we   = 1'b1;
          iss_d   = '0;
          state_d = F_ISSUE;
        end
      end
      F_ISSUE: begin
        issue = 1'b1;
        iss_d = iss_q + 1'b1;
        if (iss_q == PING_W'(PINGS - 1)) begin
          state_d = F_WAIT;
        end
      end
      F_WAIT: begin
        if (s4_vld_q && (s4_idx_q == PING_W'(PINGS - 1))) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_q <= in_word_i;
    end
  end

  assign sos_w = SOS_BASE + SOS_SLOPE * {{(SOSX_W - 8){cfg_i.ambient_temp[7]}},
                                         cfg_i.ambient_temp};
  assign sos   = sos_w[SOS_W-1:0];

  always_comb begin
    unique case (iss_q)
      2'd0:    dur = in_q.echo_time_a;
      2'd1:    dur = in_q.echo_time_b;
      default: dur = in_q.echo_time_c;
    endcase
  end

  assign dur_ok     = (dur != '0) && (dur <= cfg_i.echo_timeout);
  assign p_round    = s1_p_q + ROUND_HALF;
  assign recip_prod = PROD_W'(s2_x_q) * PROD_W'(RECIP_M);
  assign rem        = s4_x_q - s4_qm_q;
  assign q_fix      = (rem >= X_W'(DIV_RES)) ? s4_qe_q + 1'b1 : s4_qe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q  <= dur_ok;
    s1_idx_q <= iss_q;
    s1_p_q   <= P_W'(dur) * P_W'(sos);

    s2_ok_q  <= s1_ok_q && (s1_p_q >= RANGE_LO) && (s1_p_q <= RANGE_HI);
    s2_idx_q <= s1_idx_q;
    s2_x_q   <= p_round[X_W+3:4];

    s3_ok_q  <= s2_ok_q;
    s3_idx_q <= s2_idx_q;
    s3_x_q   <= s2_x_q;
    s3_qe_q  <= recip_prod[RECIP_SH+DIST_W-1:RECIP_SH];

    s4_ok_q  <= s3_ok_q;
    s4_idx_q <= s3_idx_q;
    s4_x_q   <= s3_x_q;
    s4_qe_q  <= s3_qe_q;
    s4_qm_q  <= X_W'(QM_W'(s3_qe_q) * QM_W'(DIV_RES));

    if (s4_vld_q) begin
      res_q[s4_idx_q] <= s4_ok_q ? q_fix : '0;
      rok_q[s4_idx_q] <= s4_ok_q;
    end
  end

  always_comb begin
    q_word_o.fail = 1'b0;
    unique case (rok_q)
      3'b000: begin
        q_word_o.fail = 1'b1;
        q_word_o.raw  = '0;
      end
      3'b001:  q_word_o.raw = res_q[0];
      3'b010:  q_word_o.raw = res_q[1];
      3'b100:  q_word_o.raw = res_q[2];
      3'b011:  q_word_o.raw = min2(res_q[0], res_q[1]);
      3'b101:  q_word_o.raw = min2(res_q[0], res_q[2]);
      3'b110:  q_word_o.raw = min2(res_q[1], res_q[2]);
      default: q_word_o.raw = med3(res_q[0], res_q[1], res_q[2]);
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/urc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner word queue
// Short queue of merged words between the front end and the back end.
// ----------------------------------------------------------------------------
module urc_fifo import urc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qword_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output qword_t rdata_o,
  output logic   empty_o
);

  qword_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/urc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner back end
// Health tracking, spike hold, stuck detection and the rolling median, with
// the output register that holds one result word.
// ----------------------------------------------------------------------------
module urc_back import urc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  qword_t    q_word_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t out_word_o
);

  back_state_e       state_q, state_d;
  qword_t            wrd_q, wrd_d;
  logic [DIST_W-1:0] last_q, last_d;
  logic [DIST_W-1:0] pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]  fail_run_q, fail_run_d;
  logic [CNT_W-1:0]  stuck_run_q, stuck_run_d;
  health_e           health_q, health_d, health_h;
  logic [DIST_W-1:0] win_q [WINDOW];
  logic              win_we;
  logic [WIN_IDX_W-1:0] wpos_q, wpos_d;
  logic              wfull_q, wfull_d;
  logic [WIN_IDX_W-1:0] scan_q, scan_d;
  out_word_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [DIST_W-1:0] diff_la, diff_pd;
  logic [CNT_W-1:0]  fr_inc, sr_inc;
  logic              spike, go_on;
  logic [DIST_W-1:0] cand;
  logic [WIN_CNT_W-1:0] lt_cnt, le_cnt;

  function automatic logic [DIST_W-1:0] absdiff(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic out_word_t mk_out(input logic [DIST_W-1:0] dval,
                                       input logic valid, input logic held,
                                       input health_e hl,
                                       input logic [DIST_W-1:0] obst);
    out_word_t o;
    o.distance_q4    = valid ? dval : '0;
    o.distance_valid = valid;
    o.held_value     = valid && held;
    o.sensor_health  = hl;
    o.obstacle_near  = valid && (dval < obst);
    return o;
  endfunction

  assign diff_la = absdiff(wrd_q.raw, last_q);
  assign diff_pd = absdiff(wrd_q.raw, pend_q);
  assign fr_inc  = (fail_run_q == CNT_MAX) ? fail_run_q : fail_run_q + 1'b1;
  assign sr_inc  = (stuck_run_q == CNT_MAX) ? stuck_run_q : stuck_run_q + 1'b1;
  assign spike   = (diff_la > cfg_i.jump_limit) && (last_q != '0);
  assign cand    = win_q[scan_q];

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < WINDOW; i++) begin
      lt_cnt = lt_cnt + WIN_CNT_W'(win_q[i] < cand);
      le_cnt = le_cnt + WIN_CNT_W'(win_q[i] <= cand);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      last_q      <= LAST_RESET;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      fail_run_q  <= '0;
      stuck_run_q <= '0;
      health_q    <= HEALTH_OK;
      wpos_q      <= '0;
      wfull_q     <= 1'b0;
      scan_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      pend_vld_q  <= pend_vld_d;
      fail_run_q  <= fail_run_d;
      stuck_run_q <= stuck_run_d;
      health_q    <= health_d;
      wpos_q      <= wpos_d;
      wfull_q     <= wfull_d;
      scan_q      <= scan_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wrd_q <= wrd_d;
    out_q <= out_d;
    if (win_we) begin
      win_q[wpos_q] <= wrd_q.raw;
    end
  end

  always_comb begin
    state_d     = state_q;
    wrd_d       = wrd_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    fail_run_d  = fail_run_q;
    stuck_run_d = stuck_run_q;
    health_d    = health_q;
    health_h    = health_q;
    wpos_d      = wpos_q;
    wfull_d     = wfull_q;
    scan_d      = scan_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !pop_i;
    win_we      = 1'b0;
    q_pop_o     = 1'b0;
    go_on       = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i && !out_vld_q) begin
          q_pop_o = 1'b1;
          wrd_d   = q_word_i;
          state_d = B_EVAL;
        end
      end
      B_EVAL: begin
        state_d = B_IDLE;
        if (wrd_q.fail) begin
          fail_run_d = fr_inc;
          if (fr_inc >= cfg_i.fail_limit) begin
            health_d = HEALTH_FAILED;
          end else if (fr_inc >= DEGRADE_RUN) begin
            health_d = HEALTH_DEGRADED;
          end
          out_d     = mk_out('0, 1'b0, 1'b0, health_d, cfg_i.obstacle_threshold);
          out_vld_d = 1'b1;
        end else begin
          if (spike) begin
            if (!pend_vld_q) begin
              pend_d     = wrd_q.raw;
              pend_vld_d = 1'b1;
              out_d      = mk_out(last_q, 1'b1, 1'b1, health_q,
                                  cfg_i.obstacle_threshold);
              out_vld_d  = 1'b1;
            end else if (diff_pd < CONFIRM_Q4) begin
              pend_d     = '0;
              pend_vld_d = 1'b0;
              go_on      = 1'b1;
            end else begin
              pend_d    = wrd_q.raw;
              out_d     = mk_out(last_q, 1'b1, 1'b1, health_q,
                                 cfg_i.obstacle_threshold);
              out_vld_d = 1'b1;
            end
          end else begin
            pend_d     = '0;
            pend_vld_d = 1'b0;
            go_on      = 1'b1;
          end
          if (go_on) begin
            if (diff_la < cfg_i.still_band) begin
              stuck_run_d = sr_inc;
            end else begin
              stuck_run_d = '0;
              if (health_q == HEALTH_FAILED) begin
                health_h = HEALTH_OK;
              end
            end
            if ((diff_la < cfg_i.still_band) && (sr_inc >= cfg_i.stuck_limit)) begin
              health_d  = HEALTH_FAILED;
              out_d     = mk_out('0, 1'b0, 1'b0, HEALTH_FAILED,
                                 cfg_i.obstacle_threshold);
              out_vld_d = 1'b1;
            end else begin
              health_d   = (health_h == HEALTH_DEGRADED) ? HEALTH_OK : health_h;
              last_d     = wrd_q.raw;
              fail_run_d = '0;
              win_we     = 1'b1;
              if (wpos_q == WIN_IDX_W'(WINDOW - 1)) begin
                wpos_d  = '0;
                wfull_d = 1'b1;
              end else begin
                wpos_d = wpos_q + 1'b1;
              end
              if (wfull_q || (wpos_q == WIN_IDX_W'(WINDOW - 1))) begin
                scan_d  = '0;
                state_d = B_SCAN;
              end else begin
                out_d     = mk_out(wrd_q.raw, 1'b1, 1'b0, health_d,
                                   cfg_i.obstacle_threshold);
                out_vld_d = 1'b1;
              end
            end
          end
        end
      end
      B_SCAN: begin
        if (((lt_cnt <= WIN_CNT_W'(MED_RANK)) && (le_cnt > WIN_CNT_W'(MED_RANK)))
            || (scan_q == WIN_IDX_W'(WINDOW - 1))) begin
          out_d     = mk_out(cand, 1'b1, 1'b0, health_q, cfg_i.obstacle_threshold);
          out_vld_d = 1'b1;
          state_d   = B_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign empty_o    = !out_vld_q;
  assign out_word_o = out_q;

endmodule
`default_nettype wire

@@ hdl/ultrasonic_range_conditioner_core.sv @@
// Path: the front end registers a word and runs its three pings through one
// shared converter; the merged word passes the queue, the back end evaluation,
// the median scan once the window is full, and the output register. The front
// end takes no new word until the last one has been pushed into the queue.
// Reset: asynchronous, active low; clears control state and loads the register
// defaults. The window contents are undefined until written; nothing clears them.
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner
// Converts three echo durations into a conditioned distance with health,
// spike hold, stuck detection and a rolling median.
// ----------------------------------------------------------------------------
module ultrasonic_range_conditioner_core import urc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t   cfg_q;
  logic   fq_push, fq_full, fq_pop, fq_empty;
  qword_t fq_wdata, fq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ambient_temp       <= 8'sd25;
      cfg_q.echo_timeout       <= 16'd30000;
      cfg_q.jump_limit         <= 13'd480;
      cfg_q.still_band         <= 13'd8;
      cfg_q.stuck_limit        <= 8'd20;
      cfg_q.fail_limit         <= 8'd10;
      cfg_q.obstacle_threshold <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_AMBIENT_TEMP:       cfg_q.ambient_temp       <= cfg_wdata_i[7:0];
        CFG_ECHO_TIMEOUT:       cfg_q.echo_timeout       <= cfg_wdata_i;
        CFG_JUMP_LIMIT:         cfg_q.jump_limit         <= cfg_wdata_i[DIST_W-1:0];
        CFG_STILL_BAND:         cfg_q.still_band         <= cfg_wdata_i[DIST_W-1:0];
        CFG_STUCK_LIMIT:        cfg_q.stuck_limit        <= cfg_wdata_i[CNT_W-1:0];
        CFG_FAIL_LIMIT:         cfg_q.fail_limit         <= cfg_wdata_i[CNT_W-1:0];
        CFG_OBSTACLE_THRESHOLD: cfg_q.obstacle_threshold <= cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  urc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .full_o    (full),
    .in_word_i (in_word_i),
    .q_push_o  (fq_push),
    .q_full_i  (fq_full),
    .q_word_o  (fq_wdata)
  );

  urc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .rdata_o (fq_rdata),
    .empty_o (fq_empty)
  );

  urc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (fq_empty),
    .q_word_i   (fq_rdata),
    .q_pop_o    (fq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

@@ hdl/urc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic range conditioner checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module urc_checker import urc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_word_t res_word_i
);

  a_hold_until_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_word_i)))
    else $error("result word changed before it was taken");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_word_i.distance_valid) |->
      (res_word_i.distance_q4 == '0 && !res_word_i.held_value &&
       !res_word_i.obstacle_near))
    else $error("word without distance carries distance fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_word_i.distance_valid) |->
      (res_word_i.distance_q4 >= 13'd32 && res_word_i.distance_q4 <= 13'd6400))
    else $error("reported distance out of range");

  a_health_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_word_i.sensor_health != 2'd3))
    else $error("health code out of range");

endmodule

bind ultrasonic_range_conditioner_core urc_checker u_urc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .res_word_i (out_word_o)
);
`default_nettype wire
